FILE: rtl/ismt_pkg.sv
// Package for the integer set membership table.
// Holds the table size, derived widths, command and state codes and the result type.
// No dependencies.
`default_nettype none

package ismt_pkg;

	// Table size and derived widths
	localparam int DEPTH   = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int CMD_W   = 2;
	localparam int COUNT_W = 5;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [COUNT_W-1:0] count_out_t;
	typedef logic [VALUE_W-1:0] value_t;

	// Request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_FIND   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_ERASE  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_APPLY,
		ST_RESULT
	} state_t;

	// Result handed from the sequencer to the output stage
	typedef struct packed {
		logic       found;
		logic       changed;
		logic       full_reject;
		count_out_t member_count;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/ismt_if.sv
// Channel interfaces of the integer set membership table: request and response.
// Depends on ismt_pkg for the field widths.
`default_nettype none

interface ismt_req_if import ismt_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [VALUE_W-1:0] item_value;

	modport source (output valid, output cmd, output item_value, input ready);
	modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface ismt_rsp_if import ismt_pkg::*;;
	logic             valid;
	logic             ready;
	logic             found;
	logic             changed;
	logic             full_reject;
	logic [COUNT_W-1:0] member_count;

	modport source (output valid, output found, output changed, output full_reject,
		output member_count, input ready);
	modport sink   (input valid, input found, input changed, input full_reject,
		input member_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/ismt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module ismt_ram #(
	parameter int WIDTH = 32,
	parameter int WORDS = 16,
	parameter int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [WORDS];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ismt_ctrl.sv
// Sequencer of the set table: scans the value memory, keeps the valid bits and
// member count, and applies find, insert, erase and clear. Depends on ismt_pkg, ismt_if.
`default_nettype none

module ismt_ctrl import ismt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ismt_req_if.sink    req,
	output      logic   rd_en,
	output      idx_t   rd_addr,
	input  wire value_t rd_data,
	output      logic   wr_en,
	output      idx_t   wr_addr,
	output      value_t wr_data,
	output      logic   res_valid,
	input  wire logic   res_ready,
	output      res_t   res
);

	state_t           state_q, state_d;
	cmd_t             cmd_q;
	value_t           value_q;
	idx_t             idx_q;
	logic             vld_s1;
	idx_t             idx_s1;
	logic             hit_q;
	idx_t             hit_idx_q;
	logic             free_q;
	idx_t             free_idx_q;
	logic [DEPTH-1:0] valid_q;
	cnt_t             count_q;
	cnt_t             count_d;
	res_t             res_q;
	logic             accept;
	logic             do_insert;
	logic             do_erase;
	logic             do_clear;
	logic             reject;

	assign accept = req.valid && req.ready;

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (idx_q == idx_t'(DEPTH - 1)) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_addr = idx_q;

	// Decide the update once the scan is complete
	always_comb begin
		do_insert = (state_q == ST_APPLY) && (cmd_q == CMD_INSERT) && !hit_q && free_q;
		do_erase  = (state_q == ST_APPLY) && (cmd_q == CMD_ERASE) && hit_q;
		do_clear  = (state_q == ST_APPLY) && (cmd_q == CMD_CLEAR);
		reject    = (cmd_q == CMD_INSERT) && !hit_q && !free_q;
		if (do_clear) begin
			count_d = '0;
		end else if (do_insert) begin
			count_d = cnt_t'(count_q + 1'b1);
		end else if (do_erase) begin
			count_d = cnt_t'(count_q - 1'b1);
		end else begin
			count_d = count_q;
		end
	end

	assign wr_en   = do_insert;
	assign wr_addr = free_idx_q;
	assign wr_data = value_q;
	assign res     = res_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			count_q <= '0;
			vld_s1  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			vld_s1  <= rd_en;
			if (accept) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (vld_s1) begin
				if (valid_q[idx_s1] && (rd_data == value_q)) begin
					hit_q <= 1'b1;
				end
				if (!valid_q[idx_s1]) begin
					free_q <= 1'b1;
				end
			end
			if (do_clear) begin
				valid_q <= '0;
			end else if (do_insert) begin
				valid_q[free_idx_q] <= 1'b1;
			end else if (do_erase) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// Request capture, scan address and match positions
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			cmd_q   <= cmd_t'(req.cmd);
			value_q <= value_t'(req.item_value);
			idx_q   <= '0;
		end else if (rd_en) begin
			idx_q <= idx_t'(idx_q + 1'b1);
		end
		if (vld_s1) begin
			if (!hit_q && valid_q[idx_s1] && (rd_data == value_q)) begin
				hit_idx_q <= idx_s1;
			end
			if (!free_q && !valid_q[idx_s1]) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// Hold the result until the output stage takes it
	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			res_q.found        <= hit_q;
			res_q.changed      <= do_insert || do_erase;
			res_q.full_reject  <= reject;
			res_q.member_count <= count_out_t'(count_d);
		end
	end

	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == cnt_t'($countones(valid_q)))
		else $error("member count differs from number of valid entries");

	a_write_to_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !valid_q[wr_addr])
		else $error("insert overwrites a valid entry");

	a_insert_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> valid_q[$past(free_idx_q)])
		else $error("inserted entry not marked valid");

	a_change_not_reject: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.changed && res.full_reject))
		else $error("result flags both a change and a refusal");

endmodule

`default_nettype wire

FILE: rtl/integer_set_membership_table_top.sv
// Top level of the integer set membership table: sequencer, value memory and
// output register. Depends on ismt_pkg, ismt_if, ismt_ram and ismt_ctrl.
//
// Usage:
//   req carries one transaction per request: cmd (find, insert, erase, clear all)
//   and a signed 32-bit item_value. rsp returns one transaction per request with
//   found, changed, full_reject and member_count, in request order.
//   Entry values sit in a memory of DEPTH words read one word a cycle; valid bits
//   and the member count sit in flip-flops.
//   Each request scans the whole memory: the read states (ST_SCAN), then ST_LAST for
//   the last compare, ST_APPLY to apply the update and ST_RESULT to hand over the
//   result. A new request is taken only once the result of the previous one has been
//   handed over to the output register.
//   Reset empties the table at once; no clearing pass is needed, since entries
//   without a valid bit are never compared.
//   A stalled receiver holds the result in the output register; the next request
//   is still accepted and scanned, and waits only at hand-over.
`default_nettype none

module integer_set_membership_table_top import ismt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ismt_req_if.sink   req,
	ismt_rsp_if.source rsp
);

	logic   rd_en;
	idx_t   rd_addr;
	value_t rd_data;
	logic   wr_en;
	idx_t   wr_addr;
	value_t wr_data;
	logic   res_valid;
	logic   res_ready;
	res_t   res;
	logic   out_vld_q;
	res_t   out_q;

	ismt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	ismt_ram #(
		.WIDTH  (VALUE_W),
		.WORDS  (DEPTH),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Load the output register when it is empty or being drained
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.found        = out_q.found;
	assign rsp.changed      = out_q.changed;
	assign rsp.full_reject  = out_q.full_reject;
	assign rsp.member_count = out_q.member_count;

endmodule

`default_nettype wire
